>>> hdl/dssm_pkg.sv
// Package for the two-stacks-in-one-memory block: sizes, command and status
// codes, and the command and response transaction structs.
// No dependencies.
package dssm_pkg;

  // Memory geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  // Command kinds
  localparam logic [1:0] KIND_PUSH_A = 2'd0;
  localparam logic [1:0] KIND_PUSH_B = 2'd1;
  localparam logic [1:0] KIND_POP_A  = 2'd2;
  localparam logic [1:0] KIND_POP_B  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] data_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] top_a;
    logic signed [WORD_W-1:0] top_b;
    logic [CNT_W-1:0]         count_a_out;
    logic [CNT_W-1:0]         count_b_out;
    logic                     empty_a;
    logic                     empty_b;
  } rsp_t;

endpackage

>>> hdl/dual_stack_shared_memory.sv
// Top level of the dual stack: two stacks sharing one synchronous memory.
// Depends on dssm_pkg.
//
// Two stacks live in one DEPTH-word memory: stack A grows up from entry 0,
// stack B grows down from the last entry. A command is taken when start is
// high and busy is low; its response appears on rsp, registered from the
// EXEC state, for one cycle with done high, and busy drops in that same
// cycle, so a new command is taken only once the last one is done; the
// single memory port sets this. The accept cycle performs the push write
// or the read of the new top after a pop, and the following cycle takes
// the read data into the top registers and the response register. Results
// cannot be held off by the receiver. A push fails with overflow when the
// stacks together fill the memory, a pop on an empty stack fails with
// underflow; a failed command changes nothing. The top of an empty stack
// reads as 0 with its empty flag set. No clearing pass is needed after reset.
module dual_stack_shared_memory
  import dssm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  logic [CNT_W-1:0] count_a, count_a_next;
  logic [CNT_W-1:0] count_b, count_b_next;
  logic signed [WORD_W-1:0] top_a, top_b;

  // Held from accept to response
  logic [1:0] pend_status;
  logic       pend_load_a;
  logic       pend_load_b;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  logic             accept;
  logic [CNT_W:0]   used;
  logic             full;
  logic [1:0]       status_next;
  logic             load_a_next;
  logic             load_b_next;
  logic [CNT_W:0]   b_pop_idx;

  logic signed [WORD_W-1:0] top_a_fin, top_b_fin;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  assign used      = {1'b0, count_a} + {1'b0, count_b};
  assign full      = (used >= (CNT_W+1)'(DEPTH));
  // new top of B after a pop sits at DEPTH - count_b + 1
  assign b_pop_idx = (CNT_W+1)'(DEPTH + 1) - {1'b0, count_b};

  // Decode the command: status, new counts, memory access
  always_comb begin
    status_next  = STAT_OK;
    count_a_next = count_a;
    count_b_next = count_b;
    load_a_next  = 1'b0;
    load_b_next  = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = '0;
    case (cmd.kind)
      KIND_PUSH_A: begin
        mem_addr = count_a[ADDR_W-1:0];
        if (full) begin
          status_next = STAT_OVERFLOW;
        end else begin
          mem_we       = 1'b1;
          count_a_next = count_a + CNT_W'(1);
        end
      end
      KIND_PUSH_B: begin
        mem_addr = ADDR_W'(DEPTH - 1) - count_b[ADDR_W-1:0];
        if (full) begin
          status_next = STAT_OVERFLOW;
        end else begin
          mem_we       = 1'b1;
          count_b_next = count_b + CNT_W'(1);
        end
      end
      KIND_POP_A: begin
        mem_addr = count_a[ADDR_W-1:0] - ADDR_W'(2);
        if (count_a == '0) begin
          status_next = STAT_UNDERFLOW;
        end else begin
          count_a_next = count_a - CNT_W'(1);
          load_a_next  = (count_a_next != '0);
        end
      end
      default: begin
        mem_addr = b_pop_idx[ADDR_W-1:0];
        if (count_b == '0) begin
          status_next = STAT_UNDERFLOW;
        end else begin
          count_b_next = count_b - CNT_W'(1);
          load_b_next  = (count_b_next != '0);
        end
      end
    endcase
  end

  // Stack memory: one port, write on push, read of the new top on pop
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[mem_addr] <= cmd.data_value;
    end
    rd_data <= mem[mem_addr];
  end

  assign top_a_fin = pend_load_a ? $signed(rd_data) : top_a;
  assign top_b_fin = pend_load_b ? $signed(rd_data) : top_b;

  // Control, counts and cached tops
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count_a     <= '0;
      count_b     <= '0;
      top_a       <= '0;
      top_b       <= '0;
      done        <= 1'b0;
      pend_load_a <= 1'b0;
      pend_load_b <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state       <= ST_EXEC;
            count_a     <= count_a_next;
            count_b     <= count_b_next;
            pend_load_a <= load_a_next;
            pend_load_b <= load_b_next;
            if (status_next == STAT_OK) begin
              if (cmd.kind == KIND_PUSH_A) top_a <= cmd.data_value;
              if (cmd.kind == KIND_PUSH_B) top_b <= cmd.data_value;
              if (cmd.kind == KIND_POP_A && !load_a_next) top_a <= '0;
              if (cmd.kind == KIND_POP_B && !load_b_next) top_b <= '0;
            end
          end
        end
        ST_EXEC: begin
          state       <= ST_IDLE;
          done        <= 1'b1;
          top_a       <= top_a_fin;
          top_b       <= top_b_fin;
          pend_load_a <= 1'b0;
          pend_load_b <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Status travels with the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      rsp.status      <= pend_status;
      rsp.top_a       <= top_a_fin;
      rsp.top_b       <= top_b_fin;
      rsp.count_a_out <= count_a;
      rsp.count_b_out <= count_b;
      rsp.empty_a     <= (count_a == '0);
      rsp.empty_b     <= (count_b == '0);
    end
  end

`ifndef SYNTHESIS
  // The two stacks never hold more than the memory
  a_no_overcommit: assert property (@(posedge clk) disable iff (rst)
    used <= (CNT_W+1)'(DEPTH))
    else $error("stack counts exceed memory depth");

  // Every accepted command yields a response after the EXEC state
  a_resp_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("response missing after accepted command");

  // Block is free again while the response is shown
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while response shown");

  // Overflow only when the memory is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STAT_OVERFLOW) |-> full)
    else $error("overflow reported with free space");

  // An empty stack A reports a zero top
  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.empty_a) |-> (rsp.top_a == '0))
    else $error("empty stack A with nonzero top");
`endif

endmodule
